FILE: src/assert_macros.svh
// Assertion macros used by the port checker of the sweep unit.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PFS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PFS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pfs_pkg.sv
// Types and constants of the pulse frequency sweep unit.
// No dependencies; imported by every module of the block.
package pfs_pkg;

    // Highest frequency a sweep may write before the channel is switched off
    localparam logic [15:0] FREQ_MAX = 16'd2047;

    // Masks applied to the sweep register and its fields
    localparam logic [7:0] SWEEP_MASK  = 8'h7F;
    localparam logic [2:0] FIELD_MASK  = 3'h7;

    typedef enum logic [2:0] {
        OP_WRITE   = 3'd0,
        OP_READ    = 3'd1,
        OP_TRIGGER = 3'd2,
        OP_TICK    = 3'd3,
        OP_RESET   = 3'd4
    } pfs_op_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  write_data;
        logic [10:0] channel_frequency;
    } pfs_in_t;

    typedef struct packed {
        logic [6:0]  read_data;
        logic        frequency_written;
        logic [10:0] new_frequency;
        logic        channel_disable;
    } pfs_out_t;

endpackage

FILE: src/pfs_core.sv
// Sweep state registers and the single-pass sweep step for one item.
// Depends on pfs_pkg.
module pfs_core
    import pfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  pfs_in_t  item,
    output pfs_out_t result
);

    logic [6:0]  sweep_reg,    sweep_next;
    logic [2:0]  counter_reg,  counter_next;
    logic [2:0]  shift_reg,    shift_next;
    logic        subtract_reg, subtract_next;
    logic [2:0]  period_reg,   period_next;
    logic [10:0] shadow_reg,   shadow_next;

    logic [2:0]  counter_inc;
    logic [10:0] delta;
    logic [11:0] sum;
    logic [10:0] diff;
    logic        written;
    logic        disable_chan;
    logic [10:0] new_freq;

    // Step datapath: shift, add and subtract against the shadow
    always_comb
    begin
        counter_inc = counter_reg + 3'd1;
        delta       = shadow_reg >> shift_reg;
        sum         = {1'b0, shadow_reg} + {1'b0, delta};
        diff        = shadow_reg - delta;
    end

    // Next state and result for the item leaving the input register
    always_comb
    begin
        sweep_next    = sweep_reg;
        counter_next  = counter_reg;
        shift_next    = shift_reg;
        subtract_next = subtract_reg;
        period_next   = period_reg;
        shadow_next   = shadow_reg;
        written       = 1'b0;
        disable_chan  = 1'b0;
        new_freq      = '0;

        unique case (item.operation)
            OP_WRITE:
            begin
                sweep_next = item.write_data[6:0] & SWEEP_MASK[6:0];
            end
            OP_TRIGGER:
            begin
                counter_next  = '0;
                shift_next    = sweep_reg[2:0] & FIELD_MASK;
                subtract_next = sweep_reg[3];
                period_next   = sweep_reg[6:4] & FIELD_MASK;
                shadow_next   = item.channel_frequency;
            end
            OP_RESET:
            begin
                // Clear the register, then trigger from the cleared value
                sweep_next    = '0;
                counter_next  = '0;
                shift_next    = '0;
                subtract_next = 1'b0;
                period_next   = '0;
                shadow_next   = item.channel_frequency;
            end
            OP_TICK:
            begin
                if (period_reg != 3'd0)
                begin
                    if (counter_inc >= period_reg)
                    begin
                        counter_next = '0;
                        if (shift_reg != 3'd0)
                        begin
                            if (subtract_reg)
                            begin
                                new_freq    = diff;
                                shadow_next = diff;
                                written     = 1'b1;
                            end
                            else if (sum[11] || ({4'b0, sum} > FREQ_MAX))
                            begin
                                disable_chan = 1'b1;
                            end
                            else
                            begin
                                new_freq    = sum[10:0];
                                shadow_next = sum[10:0];
                                written     = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        counter_next = counter_inc;
                    end
                end
            end
            OP_READ:
            begin
                sweep_next = sweep_reg;
            end
            default:
            begin
                sweep_next = sweep_reg;
            end
        endcase

        result.read_data         = sweep_next;
        result.frequency_written = written;
        result.new_frequency     = new_freq;
        result.channel_disable   = disable_chan;
    end

    // Commit state as the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg    <= '0;
            counter_reg  <= '0;
            shift_reg    <= '0;
            subtract_reg <= 1'b0;
            period_reg   <= '0;
            shadow_reg   <= '0;
        end
        else if (advance)
        begin
            sweep_reg    <= sweep_next;
            counter_reg  <= counter_next;
            shift_reg    <= shift_next;
            subtract_reg <= subtract_next;
            period_reg   <= period_next;
            shadow_reg   <= shadow_next;
        end
    end

endmodule

FILE: src/pulse_frequency_sweep_unit.sv
// Top level of the pulse frequency sweep unit: input and result registers.
// Depends on pfs_pkg and pfs_core.
//
//   channel | handshake         | payload
//   --------+-------------------+-------------------
//   in      | in_valid/in_stall | pfs_in_t  in_data
//   out     | out_valid/out_stall | pfs_out_t out_data
//
// Each item passes from transfer in through the input register and then the
// result register; the sweep step sits between them.
// One item is accepted every cycle while the output is not stalled.
// Reset clears the sweep state and both valid flags.
// A stalled output holds its result; the input stalls only when the
// input register is full and cannot move on.
module pulse_frequency_sweep_unit
    import pfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  pfs_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output pfs_out_t out_data
);

    logic     in_valid_reg;
    pfs_in_t  in_item_reg;
    logic     out_valid_reg;
    pfs_out_t out_item_reg;
    pfs_out_t result;
    logic     advance;
    logic     accept;

    // Move the held item on when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    pfs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    // Hold the incoming transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= in_data;
        end
    end

    // Register the result until the output transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

FILE: src/pfs_checker.sv
// Port-level checks for the pulse frequency sweep unit, bound to the top.
// Depends on pfs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pfs_checker
    import pfs_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input pfs_in_t  in_data,
    input logic     out_valid,
    input logic     out_stall,
    input pfs_out_t out_data
);

    // A stalled input transfer stays offered and unchanged
    `PFS_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_data), "stalled input changed")

    // A stalled result stays valid and unchanged
    `PFS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

    // Input stalls only behind a stalled result
    `PFS_ASSERT_NOW(a_in_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without output stall")

    // A step either writes a frequency or disables the channel, never both
    `PFS_ASSERT_NOW(a_excl, clk, rst_n, out_valid, !(out_data.frequency_written && out_data.channel_disable), "write and disable together")

    // No frequency is reported unless one was written
    `PFS_ASSERT_NOW(a_freq_zero, clk, rst_n, out_valid && !out_data.frequency_written, out_data.new_frequency == '0, "frequency reported without write")

endmodule

bind pulse_frequency_sweep_unit pfs_checker u_pfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

FILE: dv/pulse_frequency_sweep_checker.sv
`timescale 1ns / 1ps
// Result checker for the pulse frequency sweep unit: predicts every result from the
// accepted inputs and compares it with what leaves the output channel.
// Depends on pfs_pkg for the channel payload types and operation codes.
module pulse_frequency_sweep_checker
    import pfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_stall,
    input  pfs_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_stall,
    input  pfs_out_t out_data,
    output int       mismatches,
    output int       outstanding,
    output int       results_checked,
    output int       sweeps_written,
    output int       overflows
);

    // Predicted sweep state
    logic [6:0]  sweep_bits;
    logic [2:0]  tick_count;
    logic [2:0]  shift_amt;
    logic        subtract_mode;
    logic [2:0]  sweep_period;
    logic [10:0] shadow_freq;

    pfs_out_t pending_results[$];
    int       fail_count;
    int       checked_count;
    int       written_count;
    int       overflow_count;

    // Latch shift, direction and period, restart the counter, copy the frequency
    function automatic void latch_sweep_settings(input logic [10:0] freq);
        tick_count    = '0;
        shift_amt     = sweep_bits[2:0];
        subtract_mode = sweep_bits[3];
        sweep_period  = sweep_bits[6:4];
        shadow_freq   = freq;
    endfunction

    // Apply one operation to the predicted state and return its result
    function automatic pfs_out_t sweep_step(input pfs_in_t item);
        pfs_out_t    res;
        logic [10:0] delta;
        logic [11:0] sum;
        res = '0;
        case (item.operation)
            OP_WRITE:   sweep_bits = item.write_data[6:0];
            OP_TRIGGER: latch_sweep_settings(item.channel_frequency);
            OP_RESET:
            begin
                sweep_bits = '0;
                latch_sweep_settings(item.channel_frequency);
            end
            OP_TICK:
            begin
                if (sweep_period != 3'd0)
                begin
                    tick_count = tick_count + 3'd1;
                    if (tick_count >= sweep_period)
                    begin
                        tick_count = '0;
                        if (shift_amt != 3'd0)
                        begin
                            delta = shadow_freq >> shift_amt;
                            if (subtract_mode)
                            begin
                                if (delta <= shadow_freq)
                                begin
                                    shadow_freq           = shadow_freq - delta;
                                    res.frequency_written = 1'b1;
                                    res.new_frequency     = shadow_freq;
                                end
                            end
                            else
                            begin
                                sum = {1'b0, shadow_freq} + {1'b0, delta};
                                if (sum > FREQ_MAX || sum > 12'h7FF)
                                    res.channel_disable = 1'b1;
                                else
                                begin
                                    shadow_freq           = sum[10:0];
                                    res.frequency_written = 1'b1;
                                    res.new_frequency     = shadow_freq;
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        res.read_data = sweep_bits;
        return res;
    endfunction

    // Report one field that differs from its prediction
    task automatic check_field(input string name, input int predicted, input int seen);
        if (predicted != seen)
        begin
            $error("%s: expected %0d, actual %0d", name, predicted, seen);
            fail_count++;
        end
    endtask

    // Compare each result transfer, then queue the prediction for each input transfer
    always @(posedge clk or negedge rst_n)
    begin
        pfs_out_t want;
        if (!rst_n)
        begin
            sweep_bits      = '0;
            tick_count      = '0;
            shift_amt       = '0;
            subtract_mode   = 1'b0;
            sweep_period    = '0;
            shadow_freq     = '0;
            pending_results.delete();
            fail_count      = 0;
            checked_count   = 0;
            written_count   = 0;
            overflow_count  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with nothing expected: read_data %0d",
                           out_data.read_data);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("read_data", want.read_data, out_data.read_data);
                    check_field("frequency_written", want.frequency_written,
                                out_data.frequency_written);
                    check_field("new_frequency", want.new_frequency, out_data.new_frequency);
                    check_field("channel_disable", want.channel_disable,
                                out_data.channel_disable);
                    checked_count++;
                    if (want.frequency_written)
                        written_count++;
                    if (want.channel_disable)
                        overflow_count++;
                end
            end
            if (in_valid && !in_stall)
                pending_results.push_back(sweep_step(in_data));
        end
        mismatches      <= fail_count;
        outstanding     <= pending_results.size();
        results_checked <= checked_count;
        sweeps_written  <= written_count;
        overflows       <= overflow_count;
    end

endmodule

FILE: dv/pulse_frequency_sweep_unit_test.sv
`timescale 1ns / 1ps
// Top of the sweep unit testbench: clock, reset, stimulus, output stalls and verdict.
// Depends on pfs_pkg, pulse_frequency_sweep_unit and pulse_frequency_sweep_checker.
module pulse_frequency_sweep_unit_test;
    import pfs_pkg::*;

    // Operation codes the block leaves undecoded
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int ITEM_TARGET    = 1250;
    localparam int QUIET_FROM     = 1100;
    localparam int CYCLE_LIMIT    = 300000;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    pfs_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    pfs_out_t out_data;

    logic idling       = 1'b0;
    int   stall_left   = 0;
    int   cycle_count  = 0;
    int   items_sent   = 0;
    int   mismatches;
    int   outstanding;
    int   results_checked;
    int   sweeps_written;
    int   overflows;

    pulse_frequency_sweep_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    pulse_frequency_sweep_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .sweeps_written  (sweeps_written),
        .overflows       (overflows)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stall the output in bursts of random length, started only while idling is enabled
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idling && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Offer one item, with an optional gap first, and hold it until the transfer
    task automatic send_item(input logic [2:0] op, input logic [7:0] wdata,
                             input logic [10:0] freq);
        pfs_in_t item;
        int      gap;
        item.operation         = op;
        item.write_data        = wdata;
        item.channel_frequency = freq;
        if (idling && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (op <= OP_RESET)
            items_sent++;
    endtask

    // Hold the input until every predicted result has left the block
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Bias frequencies towards the ends of the range so overflows and small shadows occur
    function automatic logic [10:0] pick_frequency();
        case ($urandom_range(0, 3))
            0:       return 11'($urandom_range(0, 63));
            1:       return 11'($urandom_range(1536, 2047));
            2:       return 11'($urandom_range(512, 1535));
            default: return 11'($urandom_range(0, 2047));
        endcase
    endfunction

    // Program the register, trigger, then send a run of ticks mixed with reads, writes and undecoded codes
    task automatic sweep_sequence();
        int ticks;
        send_item(OP_WRITE, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        send_item(OP_TRIGGER, 8'($urandom_range(0, 255)), pick_frequency());
        ticks = $urandom_range(1, 30);
        repeat (ticks)
        begin
            case ($urandom_range(0, 19))
                0:       send_item(OP_READ, 8'($urandom_range(0, 255)),
                                   11'($urandom_range(0, 2047)));
                1:       send_item(OP_WRITE, 8'($urandom_range(0, 255)),
                                   11'($urandom_range(0, 2047)));
                2:       send_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                                   8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
                default: send_item(OP_TICK, 8'($urandom_range(0, 255)),
                                   11'($urandom_range(0, 2047)));
            endcase
        end
    endtask

    initial
    begin
        int next_phase;
        int noise_count;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: register masking, add and overflow, subtract, zero shift,
        // zero period, undecoded codes and the reset operation
        send_item(OP_RESET, 8'hFF, 11'd2047);
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_WRITE, 8'hFF, 11'd2047);
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_WRITE, 8'h11, 11'd0);
        send_item(OP_TRIGGER, 8'h00, 11'd1024);
        send_item(OP_TICK, 8'h00, 11'd0);
        send_item(OP_TICK, 8'hFF, 11'd2047);
        send_item(OP_WRITE, 8'h1F, 11'd0);
        send_item(OP_TRIGGER, 8'h00, 11'd2047);
        send_item(OP_TICK, 8'h00, 11'd0);
        send_item(OP_WRITE, 8'h20, 11'd0);
        send_item(OP_TRIGGER, 8'h00, 11'd2047);
        send_item(OP_TICK, 8'h00, 11'd0);
        send_item(OP_TICK, 8'h00, 11'd0);
        send_item(OP_WRITE, 8'h0F, 11'd0);
        send_item(OP_TRIGGER, 8'h00, 11'd300);
        send_item(OP_TICK, 8'h00, 11'd0);
        send_item(OP_SPARE_LO, 8'hFF, 11'd2047);
        send_item(OP_SPARE_HI, 8'hAA, 11'd1365);
        send_item(OP_WRITE, 8'h71, 11'd0);
        send_item(OP_RESET, 8'h55, 11'd555);
        send_item(OP_TICK, 8'h00, 11'd0);
        send_item(OP_WRITE, 8'h80, 11'd0);
        send_item(OP_READ, 8'h00, 11'd0);

        // Random: mostly well-formed sweep sequences, some loose noise
        next_phase = items_sent;
        noise_count = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= QUIET_FROM)
                idling <= 1'b0;
            else if (items_sent >= next_phase)
            begin
                idling <= ($urandom_range(0, 3) != 0);
                next_phase = next_phase + 150;
            end
            if (items_sent >= ITEM_TARGET / 2 && noise_count >= 0)
            begin
                drain_results();
                noise_count = -1;
            end
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              11'($urandom_range(0, 2047)));
            end
            else
                sweep_sequence();
        end

        // Let the last results out, then give the verdict
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (6) @(posedge clk);
        $display("Sent %0d decoded operations; %0d results compared field by field.",
                 items_sent, results_checked);
        $display("Sweeps wrote back %0d frequencies and shut the channel off %0d times.",
                 sweeps_written, overflows);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: pulse_frequency_sweep_unit.f
+incdir+src
src/pfs_pkg.sv
src/pfs_core.sv
src/pulse_frequency_sweep_unit.sv
src/pfs_checker.sv
dv/pulse_frequency_sweep_checker.sv
dv/pulse_frequency_sweep_unit_test.sv
